FILE: rtl/core/tracker_pattern_unpacker_unit_assert.svh
// Assertion shorthands for the pattern unpacker checkers.
// Both sample on the rising edge of clk and stay quiet while rst_n is low.
`ifndef TRACKER_PATTERN_UNPACKER_UNIT_ASSERT_SVH
`define TRACKER_PATTERN_UNPACKER_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define TPU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define TPU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/tpu_pkg.sv
package tpu_pkg;

    // Default number of channel slots
    localparam int NUM_CHANNELS_DEF = 64;

    // Parser phases
    localparam logic [2:0] PH_CHAN = 3'd0;
    localparam logic [2:0] PH_MASK = 3'd1;
    localparam logic [2:0] PH_NOTE = 3'd2;
    localparam logic [2:0] PH_INS  = 3'd3;
    localparam logic [2:0] PH_VOL  = 3'd4;
    localparam logic [2:0] PH_CMD  = 3'd5;
    localparam logic [2:0] PH_DATA = 3'd6;

    // Mask bit pairs: new value or remembered value
    localparam logic [7:0] MASK_NOTE = 8'h11;
    localparam logic [7:0] MASK_INS  = 8'h22;
    localparam logic [7:0] MASK_VOL  = 8'h44;
    localparam logic [7:0] MASK_CMD  = 8'h88;

    // Highest note that is stored incremented
    localparam logic [7:0] NOTE_MAX = 8'd120;

    // One channel's remembered entry
    typedef struct packed {
        logic [7:0] mask;
        logic [7:0] note;
        logic [7:0] ins;
        logic [7:0] volpan;
        logic [7:0] cmd;
        logic [7:0] cmd_val;
    } tpu_rec_t;

    localparam int REC_W = $bits(tpu_rec_t);

    // First data phase for mask bits at or above 'from'; PH_CHAN if none
    function automatic logic [2:0] next_phase(input logic [1:0] from, input logic [7:0] m);
        logic [2:0] ph;
        ph = PH_CHAN;
        for (int k = 3; k >= 0; k--) begin
            if ((k >= int'(from)) && m[k])
            begin
                ph = PH_NOTE + 3'(k);
            end
        end
        return ph;
    endfunction

endpackage

FILE: rtl/core/tpu_ram.sv
module tpu_ram #(
    parameter int WIDTH = tpu_pkg::REC_W,
    parameter int DEPTH = tpu_pkg::NUM_CHANNELS_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port (read returns old data)
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/core/tracker_pattern_unpacker_unit.sv
// An event leaves through the input register and then the result register
// once its completing byte is taken.
// Throughput: one byte per cycle; the single read port of the channel RAM,
// read with the incoming byte, paces the stream. Output stalls hold the input.
// Reset (rst_n, async): parser, valid bits and channel high mark clear at once;
// the channel RAM is masked by per-row valid bits, so no clearing pass.
module tracker_pattern_unpacker_unit #(
    parameter int NUM_CHANNELS = tpu_pkg::NUM_CHANNELS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] data_byte,
    input  logic       pattern_start,
    input  logic       byte_valid,
    output logic       byte_ready,
    output logic       event_valid,
    input  logic       event_ready,
    output logic       row_end,
    output logic [6:0] channel,
    output logic [7:0] note,
    output logic [7:0] instrument,
    output logic [7:0] volume_pan,
    output logic [7:0] effect_command,
    output logic [7:0] effect_value,
    output logic [6:0] channels_used
);

    import tpu_pkg::*;

    localparam int         IDX_W   = $clog2(NUM_CHANNELS);
    localparam logic [6:0] CH_LAST = 7'(NUM_CHANNELS - 1);

    // Channel byte to slot index, saturated at the last slot
    function automatic logic [IDX_W-1:0] chan_idx(input logic [7:0] b);
        logic [5:0] raw;
        raw = b[5:0] - 6'd1;
        if ({1'b0, raw} > CH_LAST)
        begin
            return CH_LAST[IDX_W-1:0];
        end
        return raw[IDX_W-1:0];
    endfunction

    // Input register
    logic             in_valid_reg;
    logic [7:0]       byte_reg;
    logic             pstart_reg;

    // Parser state and working copy of the current channel's entry
    logic [2:0]        phase_reg,  phase_next;
    logic [IDX_W-1:0]  cur_ch_reg, cur_ch_next;
    tpu_rec_t          rec_reg,    rec_next;
    logic [6:0]        max_reg,    max_next;
    logic [NUM_CHANNELS-1:0] row_valid_reg;

    // Result register
    logic       event_valid_reg;
    logic       row_end_reg;
    logic [6:0] channel_reg;
    logic [7:0] note_reg;
    logic [7:0] ins_reg;
    logic [7:0] vol_reg;
    logic [7:0] cmd_reg;
    logic [7:0] val_reg;
    logic [6:0] used_reg;

    logic             accept;
    logic             fire;
    logic [REC_W-1:0] ram_rd;
    tpu_rec_t         ram_rec;
    logic             do_write;
    logic             do_emit;
    logic             do_row_end;
    logic             do_start;
    logic [2:0]       eff_phase;
    logic [IDX_W-1:0] eff_ch;
    tpu_rec_t         eff_rec;
    logic [IDX_W-1:0] new_ch;

    // Handshake: stage advances whenever the result slot is free or drains
    assign accept     = byte_valid & byte_ready;
    assign fire       = in_valid_reg & (~event_valid_reg | event_ready);
    assign byte_ready = ~in_valid_reg | fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (byte_ready)
        begin
            in_valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg   <= data_byte;
            pstart_reg <= pattern_start;
        end
    end

    // Channel RAM: read speculatively at the slot the incoming byte would select
    tpu_ram #(
        .WIDTH (REC_W),
        .DEPTH (NUM_CHANNELS)
    ) u_tpu_ram (
        .clk     (clk),
        .wr_en   (do_write & fire),
        .wr_addr (cur_ch_next),
        .wr_data (rec_next),
        .rd_en   (accept),
        .rd_addr (chan_idx(data_byte)),
        .rd_data (ram_rd)
    );

    assign ram_rec = tpu_rec_t'(ram_rd);
    assign new_ch  = chan_idx(byte_reg);

    // Parse one byte
    always_comb
    begin
        eff_phase   = pstart_reg ? PH_CHAN : phase_reg;
        eff_ch      = pstart_reg ? '0 : cur_ch_reg;
        eff_rec     = pstart_reg ? '0 : rec_reg;
        phase_next  = PH_CHAN;
        cur_ch_next = eff_ch;
        rec_next    = eff_rec;
        max_next    = max_reg;
        do_write    = 1'b0;
        do_emit     = 1'b0;
        do_row_end  = 1'b0;
        do_start    = 1'b0;

        case (eff_phase)
            PH_MASK:
            begin
                rec_next.mask = byte_reg;
                do_write      = 1'b1;
                do_start      = 1'b1;
            end
            PH_NOTE:
            begin
                rec_next.note = (byte_reg <= NOTE_MAX) ? byte_reg + 8'd1 : byte_reg;
                do_write      = 1'b1;
                phase_next    = next_phase(2'd1, eff_rec.mask);
                do_emit       = (phase_next == PH_CHAN);
            end
            PH_INS:
            begin
                rec_next.ins = byte_reg;
                do_write     = 1'b1;
                phase_next   = next_phase(2'd2, eff_rec.mask);
                do_emit      = (phase_next == PH_CHAN);
            end
            PH_VOL:
            begin
                rec_next.volpan = byte_reg + 8'd1;
                do_write        = 1'b1;
                phase_next      = next_phase(2'd3, eff_rec.mask);
                do_emit         = (phase_next == PH_CHAN);
            end
            PH_CMD:
            begin
                rec_next.cmd = byte_reg;
                do_write     = 1'b1;
                phase_next   = PH_DATA;
            end
            PH_DATA:
            begin
                rec_next.cmd_val = byte_reg;
                do_write         = 1'b1;
                do_emit          = 1'b1;
            end
            default:
            begin
                if (byte_reg == 8'd0)
                begin
                    do_row_end = 1'b1;
                end
                else
                begin
                    cur_ch_next = new_ch;
                    // Working copy is newest for the current slot; RAM may lag it
                    if (new_ch == eff_ch)
                    begin
                        rec_next = eff_rec;
                    end
                    else if (row_valid_reg[new_ch] && !pstart_reg)
                    begin
                        rec_next = ram_rec;
                    end
                    else
                    begin
                        rec_next = '0;
                    end
                    if (byte_reg[7])
                    begin
                        phase_next = PH_MASK;
                    end
                    else
                    begin
                        do_start = 1'b1;
                    end
                end
            end
        endcase

        // Entry start: empty mask is skipped, otherwise raise the high mark and pick the first data phase
        if (do_start && (rec_next.mask != 8'd0))
        begin
            if (max_reg <= 7'(cur_ch_next))
            begin
                max_next = 7'(cur_ch_next) + 7'd1;
            end
            phase_next = next_phase(2'd0, rec_next.mask);
            do_emit    = (phase_next == PH_CHAN);
        end
    end

    // Parser state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_CHAN;
            cur_ch_reg    <= '0;
            rec_reg       <= '0;
            max_reg       <= '0;
            row_valid_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            cur_ch_reg <= cur_ch_next;
            rec_reg    <= rec_next;
            max_reg    <= max_next;
            if (pstart_reg)
            begin
                row_valid_reg <= '0;
            end
            else if (do_write)
            begin
                row_valid_reg[cur_ch_next] <= 1'b1;
            end
        end
    end

    // Result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            event_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            event_valid_reg <= do_emit | do_row_end;
        end
        else if (event_ready)
        begin
            event_valid_reg <= 1'b0;
        end
    end

    // Result payload; fields not announced by the mask read as zero
    always_ff @(posedge clk)
    begin
        if (fire && (do_emit || do_row_end))
        begin
            row_end_reg <= do_row_end;
            channel_reg <= do_emit ? 7'(cur_ch_next) + 7'd1 : 7'd0;
            note_reg    <= (do_emit && ((rec_next.mask & MASK_NOTE) != 8'd0))
                           ? rec_next.note : 8'd0;
            ins_reg     <= (do_emit && ((rec_next.mask & MASK_INS) != 8'd0))
                           ? rec_next.ins : 8'd0;
            vol_reg     <= (do_emit && ((rec_next.mask & MASK_VOL) != 8'd0))
                           ? rec_next.volpan : 8'd0;
            cmd_reg     <= (do_emit && ((rec_next.mask & MASK_CMD) != 8'd0))
                           ? rec_next.cmd : 8'd0;
            val_reg     <= (do_emit && ((rec_next.mask & MASK_CMD) != 8'd0))
                           ? rec_next.cmd_val : 8'd0;
            used_reg    <= do_emit ? max_next : 7'd0;
        end
    end

    assign event_valid    = event_valid_reg;
    assign row_end        = row_end_reg;
    assign channel        = channel_reg;
    assign note           = note_reg;
    assign instrument     = ins_reg;
    assign volume_pan     = vol_reg;
    assign effect_command = cmd_reg;
    assign effect_value   = val_reg;
    assign channels_used  = used_reg;

endmodule

FILE: rtl/core/tpu_checker.sv
`include "tracker_pattern_unpacker_unit_assert.svh"

module tpu_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       byte_ready,
    input logic       event_valid,
    input logic       event_ready,
    input logic       row_end,
    input logic [6:0] channel,
    input logic [7:0] note,
    input logic [7:0] instrument,
    input logic [7:0] volume_pan,
    input logic [7:0] effect_command,
    input logic [7:0] effect_value,
    input logic [6:0] channels_used
);

    // Stalled beat keeps its contents
    `TPU_ASSERT_NEXT(a_stall_hold, event_valid && !event_ready, event_valid && $stable(row_end) && $stable(channel) && $stable(note) && $stable(effect_value), "event beat changed while stalled")

    // Row end carries nothing else
    `TPU_ASSERT_NOW(a_row_end_clean, event_valid && row_end, channel == 7'd0 && note == 8'd0 && instrument == 8'd0 && volume_pan == 8'd0 && effect_command == 8'd0 && effect_value == 8'd0 && channels_used == 7'd0, "row end beat carries data")

    // A channel event names a slot already counted in the high mark
    `TPU_ASSERT_NOW(a_chan_counted, event_valid && !row_end, channel != 7'd0 && channels_used >= channel, "channel event beyond high mark")

    // An empty result slot never holds back the input
    `TPU_ASSERT_NOW(a_ready_when_empty, !event_valid, byte_ready, "input stalled with empty result slot")

endmodule

bind tracker_pattern_unpacker_unit tpu_checker u_tpu_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .byte_ready     (byte_ready),
    .event_valid    (event_valid),
    .event_ready    (event_ready),
    .row_end        (row_end),
    .channel        (channel),
    .note           (note),
    .instrument     (instrument),
    .volume_pan     (volume_pan),
    .effect_command (effect_command),
    .effect_value   (effect_value),
    .channels_used  (channels_used)
);
